### hw/rtl/spf_pkg.sv
// Shared constants for the sieve prime factorizer.
package spf_pkg;
    localparam int MAX_VALUE = 65535;
    localparam int AW        = $clog2(MAX_VALUE + 1);
    localparam int DEPTH     = MAX_VALUE + 1;
    localparam int VW        = 16;
    localparam int EW        = 5;
    localparam int CW        = $clog2(AW);
endpackage

### hw/rtl/spf_ram.sv
// Generic simple dual-port RAM with registered read.
module spf_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/sieve_prime_factorizer.sv
// Sieve prime factorizer: smallest-factor table build and factorization of queries.
// After reset: table clear, then the sieve (each value read and checked; each prime whose
// square fits marks its multiples); s_ready low until done. Reset sync, active low.
// Query 0 or 1: a status result (m_status high) is emitted through S_EMIT.
// Else: table lookup, per prime power a restoring division, then a table read (S_N_RD,
// S_N_CHK) unless n is 1; each result waits in S_EMIT while the output is stalled by m_ready.
// One query at a time: the next accept follows the emit of the last result.
module sieve_prime_factorizer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [spf_pkg::VW-1:0]    s_query_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [spf_pkg::VW-1:0]    m_prime_factor,
    output logic [spf_pkg::EW-1:0]    m_exponent,
    output logic                      m_query_is_prime,
    output logic                      m_status,
    output logic                      m_last
);
    import spf_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_P_RD, S_P_CHK, S_MARK, S_IDLE, S_Q_CHK, S_DIV, S_N_RD, S_N_CHK, S_EMIT
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] p_reg;
    logic [AW:0]   q_reg;
    logic [2*AW-1:0] sq_reg;
    logic          mk_v_reg;
    logic [AW-1:0] mk_addr_reg;
    logic [AW-1:0] n_reg;
    logic [AW-1:0] np_reg;
    logic [EW-1:0] e_reg;
    logic          isp_reg;
    logic [AW-1:0] dq_reg;
    logic [AW-1:0] dr_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] em_p_reg;
    logic [EW-1:0] em_e_reg;
    logic          em_isp_reg;
    logic          em_st_reg;
    logic          em_last_reg;
    logic          m_valid_reg;
    logic [VW-1:0] m_p_reg;
    logic [EW-1:0] m_e_reg;
    logic          m_isp_reg;
    logic          m_st_reg;
    logic          m_last_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

    logic [AW-1:0] query_n;
    logic          query_trivial;
    logic [AW:0]   r_sh;
    logic          r_ge;
    logic [AW:0]   r_new;
    logic [AW-1:0] q_new;

    spf_ram #(.W(AW), .D(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign query_n       = AW'(32'(s_query_value));
    assign query_trivial = (32'(s_query_value) > 32'(MAX_VALUE)) || (s_query_value < VW'(2));

    // one restoring-division step per cycle
    assign r_sh  = {dr_reg, dq_reg[AW-1]};
    assign r_ge  = r_sh >= {1'b0, p_reg};
    assign r_new = r_ge ? (r_sh - {1'b0, p_reg}) : r_sh;
    assign q_new = {dq_reg[AW-2:0], r_ge};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == AW'(1)) ? AW'(1) : '0;
            end
            S_P_RD:  ram_raddr = p_reg;
            S_P_CHK: begin
                ram_we    = (ram_rdata == '0);
                ram_waddr = p_reg;
                ram_wdata = p_reg;
            end
            S_MARK:  ram_raddr = q_reg[AW-1:0];
            S_IDLE:  ram_raddr = query_n;
            S_N_RD:  ram_raddr = n_reg;
            default: ram_raddr = '0;
        endcase
        // pending mark from the previous cycle's read
        if (mk_v_reg && ram_rdata == '0) begin
            ram_we    = 1'b1;
            ram_waddr = mk_addr_reg;
            ram_wdata = p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            mk_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mk_v_reg <= 1'b0;
            // S_EMIT reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_VALUE)) begin
                        p_reg     <= AW'(2);
                        state_reg <= S_P_RD;
                    end
                end
                S_P_RD: begin
                    sq_reg    <= (2*AW)'(p_reg) * (2*AW)'(p_reg);
                    state_reg <= S_P_CHK;
                end
                S_P_CHK: begin
                    if (ram_rdata == '0 && sq_reg <= (2*AW)'(MAX_VALUE)) begin
                        q_reg     <= sq_reg[AW:0];
                        state_reg <= S_MARK;
                    end else if (p_reg == AW'(MAX_VALUE)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        p_reg     <= p_reg + AW'(1);
                        state_reg <= S_P_RD;
                    end
                end
                S_MARK: begin
                    if (q_reg <= (AW+1)'(MAX_VALUE)) begin
                        mk_v_reg    <= 1'b1;
                        mk_addr_reg <= q_reg[AW-1:0];
                        q_reg       <= q_reg + {1'b0, p_reg};
                    end else if (p_reg == AW'(MAX_VALUE)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        p_reg     <= p_reg + AW'(1);
                        state_reg <= S_P_RD;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        if (query_trivial) begin
                            em_p_reg    <= '0;
                            em_e_reg    <= '0;
                            em_isp_reg  <= 1'b0;
                            em_st_reg   <= 1'b1;
                            em_last_reg <= 1'b1;
                            state_reg   <= S_EMIT;
                        end else begin
                            n_reg     <= query_n;
                            state_reg <= S_Q_CHK;
                        end
                    end
                end
                S_Q_CHK: begin
                    p_reg     <= ram_rdata;
                    isp_reg   <= (ram_rdata == n_reg);
                    e_reg     <= '0;
                    dq_reg    <= n_reg;
                    dr_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    dq_reg  <= q_new;
                    dr_reg  <= r_new[AW-1:0];
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(AW-1)) begin
                        n_reg <= q_new;
                        e_reg <= e_reg + EW'(1);
                        if (q_new == AW'(1)) begin
                            em_p_reg    <= p_reg;
                            em_e_reg    <= e_reg + EW'(1);
                            em_isp_reg  <= isp_reg;
                            em_st_reg   <= 1'b0;
                            em_last_reg <= 1'b1;
                            state_reg   <= S_EMIT;
                        end else begin
                            state_reg <= S_N_RD;
                        end
                    end
                end
                S_N_RD: state_reg <= S_N_CHK;
                S_N_CHK: begin
                    dq_reg  <= n_reg;
                    dr_reg  <= '0;
                    cnt_reg <= '0;
                    if (ram_rdata == p_reg) begin
                        state_reg <= S_DIV;
                    end else begin
                        np_reg      <= ram_rdata;
                        em_p_reg    <= p_reg;
                        em_e_reg    <= e_reg;
                        em_isp_reg  <= isp_reg;
                        em_st_reg   <= 1'b0;
                        em_last_reg <= 1'b0;
                        state_reg   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_p_reg     <= VW'(em_p_reg);
                        m_e_reg     <= em_e_reg;
                        m_isp_reg   <= em_isp_reg;
                        m_st_reg    <= em_st_reg;
                        m_last_reg  <= em_last_reg;
                        if (em_last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            // next prime; divider already loaded with n
                            p_reg     <= np_reg;
                            e_reg     <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                default: state_reg <= S_CLR;
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_prime_factor   = m_p_reg;
    assign m_exponent       = m_e_reg;
    assign m_query_is_prime = m_isp_reg;
    assign m_status         = m_st_reg;
    assign m_last           = m_last_reg;
endmodule
